/* rtl/core/sptt_pkg.sv */
`timescale 1ns / 1ps

package sptt_pkg;

   // Fixed widths of the request and response words.
   localparam int PAGE_W     = 32;
   localparam int OFFSET_W   = 16;
   localparam int SLOT_OUT_W = 8;

   // Configuration register widths and reset values.
   localparam int SEG_SHIFT_W  = 5;
   localparam int LIMIT_W      = 9;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 9;

   localparam logic [SEG_SHIFT_W-1:0] SEG_SHIFT_RESET  = 5'd4;
   localparam logic [LIMIT_W-1:0]     POOL_LIMIT_RESET = 9'd256;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_SEG_SHIFT  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POOL_LIMIT = 2'd1;

   // Status of the chain walker as seen by the top level.
   typedef struct packed {
      logic clearing;
      logic item_pop;
   } walk_status_type;

endpackage

/* rtl/core/sptt_front.sv */
`timescale 1ns / 1ps

module sptt_front #(
   parameter int BUCKET_BITS = 8,
   parameter int PAGE_BITS   = 32,
   parameter int BASE_W      = 32
) (
   input  logic [sptt_pkg::PAGE_W-1:0]      page_number,
   input  logic [sptt_pkg::SEG_SHIFT_W-1:0] seg_shift,
   output logic [BASE_W-1:0]                seg_base,
   output logic [BUCKET_BITS-1:0]           bucket,
   output logic [sptt_pkg::OFFSET_W-1:0]    page_offset
);
   import sptt_pkg::*;

   localparam logic [PAGE_W-1:0] PAGE_MASK = (PAGE_BITS >= PAGE_W) ? {PAGE_W{1'b1}} :
      PAGE_W'((64'd1 << PAGE_BITS) - 64'd1);

   logic [PAGE_W-1:0] page;
   logic [PAGE_W-1:0] seg_mask;
   logic [PAGE_W-1:0] base_full;
   logic [PAGE_W-1:0] shifted;
   logic [PAGE_W-1:0] offset_full;

   // Split the page number into segment base, bucket and in-segment offset.
   always_comb begin
      page        = page_number & PAGE_MASK;
      seg_mask    = (PAGE_W'(1) << seg_shift) - PAGE_W'(1);
      base_full   = page & ~seg_mask;
      shifted     = page >> seg_shift;
      offset_full = page & seg_mask;
      seg_base    = base_full[BASE_W-1:0];
      bucket      = shifted[BUCKET_BITS-1:0];
      page_offset = offset_full[OFFSET_W-1:0];
   end

endmodule

/* rtl/core/sptt_fifo.sv */
`timescale 1ns / 1ps

module sptt_fifo #(
   parameter int WIDTH = 56
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_ff;
   logic             rd_ptr_in;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage for the two queued words.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/core/sptt_walker.sv */
`timescale 1ns / 1ps

module sptt_walker #(
   parameter int BUCKET_BITS = 8,
   parameter int POOL_SLOTS  = 256,
   parameter int BASE_W      = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              item_valid,
   input  logic [BASE_W-1:0]                 item_base,
   input  logic [BUCKET_BITS-1:0]            item_bucket,
   input  logic [sptt_pkg::OFFSET_W-1:0]     item_offset,
   input  logic [sptt_pkg::LIMIT_W-1:0]      pool_limit,
   output sptt_pkg::walk_status_type         status,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [sptt_pkg::SLOT_OUT_W-1:0]   rsp_pool_slot,
   output logic [sptt_pkg::OFFSET_W-1:0]     rsp_page_offset,
   output logic                              rsp_newly_allocated,
   output logic                              rsp_table_full
);
   import sptt_pkg::*;

   localparam int BUCKETS = 1 << BUCKET_BITS;
   localparam int SLOT_W  = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
   localparam int LIM_W   = ($clog2(POOL_SLOTS + 1) > LIMIT_W) ?
                            $clog2(POOL_SLOTS + 1) : LIMIT_W;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_HEAD  = 3'd2;
   localparam logic [2:0] ST_CMP   = 3'd3;
   localparam logic [2:0] ST_ALLOC = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   // Memories: bucket heads, recorded bases and chain links.
   logic [SLOT_W-1:0] head_mem [BUCKETS];
   logic [BASE_W-1:0] base_mem [POOL_SLOTS];
   logic [SLOT_W-1:0] next_mem [POOL_SLOTS];

   logic [2:0]             state_ff, state_in;
   logic [BUCKET_BITS-1:0] clr_ff, clr_in;
   logic [BASE_W-1:0]      base_ff, base_in;
   logic [BUCKET_BITS-1:0] bucket_ff, bucket_in;
   logic [OFFSET_W-1:0]    offset_ff, offset_in;
   logic [SLOT_W-1:0]      head_ff, head_in;
   logic [SLOT_W-1:0]      cur_ff, cur_in;
   logic [SLOT_W-1:0]      used_ff, used_in;
   logic [SLOT_W-1:0]      pend_slot_ff, pend_slot_in;
   logic                   pend_fresh_ff, pend_fresh_in;
   logic                   pend_full_ff, pend_full_in;
   logic                   res_valid_ff, res_valid_in;
   logic [SLOT_W-1:0]      res_slot_ff, res_slot_in;
   logic [OFFSET_W-1:0]    res_offset_ff, res_offset_in;
   logic                   res_fresh_ff, res_fresh_in;
   logic                   res_full_ff, res_full_in;

   logic [SLOT_W-1:0]      head_rd_ff;
   logic [BASE_W-1:0]      base_rd_ff;
   logic [SLOT_W-1:0]      next_rd_ff;

   logic                   head_we;
   logic [BUCKET_BITS-1:0] head_waddr;
   logic [SLOT_W-1:0]      head_wdata;
   logic                   slot_we;
   logic [SLOT_W-1:0]      slot_raddr;

   logic [LIM_W-1:0]       limit;
   logic [LIM_W-1:0]       victim;
   logic [SLOT_W-1:0]      victim_slot;
   logic                   res_free;
   logic [31:0]            slot_ext;

   // Effective limit and the next slot to hand out.
   always_comb begin
      limit = (LIM_W'(pool_limit) > LIM_W'(POOL_SLOTS)) ? LIM_W'(POOL_SLOTS) :
              LIM_W'(pool_limit);
      victim      = LIM_W'(used_ff) + LIM_W'(1);
      victim_slot = victim[SLOT_W-1:0];
      res_free    = !res_valid_ff || rsp_pop;
   end

   // Walk sequencer.
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      base_in       = base_ff;
      bucket_in     = bucket_ff;
      offset_in     = offset_ff;
      head_in       = head_ff;
      cur_in        = cur_ff;
      used_in       = used_ff;
      pend_slot_in  = pend_slot_ff;
      pend_fresh_in = pend_fresh_ff;
      pend_full_in  = pend_full_ff;
      res_valid_in  = res_valid_ff && !rsp_pop;
      res_slot_in   = res_slot_ff;
      res_offset_in = res_offset_ff;
      res_fresh_in  = res_fresh_ff;
      res_full_in   = res_full_ff;
      head_we       = 1'b0;
      head_waddr    = bucket_ff;
      head_wdata    = victim_slot;
      slot_we       = 1'b0;
      slot_raddr    = next_rd_ff;
      status        = '{clearing: 1'b0, item_pop: 1'b0};

      unique case (state_ff)
         ST_CLEAR: begin
            status.clearing = 1'b1;
            head_we    = 1'b1;
            head_waddr = clr_ff;
            head_wdata = '0;
            clr_in     = clr_ff + BUCKET_BITS'(1);
            if (clr_ff == {BUCKET_BITS{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            // The bucket head read is issued from the queue output directly.
            if (item_valid) begin
               status.item_pop = 1'b1;
               base_in   = item_base;
               bucket_in = item_bucket;
               offset_in = item_offset;
               state_in  = ST_HEAD;
            end
         end
         ST_HEAD: begin
            head_in    = head_rd_ff;
            cur_in     = head_rd_ff;
            slot_raddr = head_rd_ff;
            state_in   = (head_rd_ff == '0) ? ST_ALLOC : ST_CMP;
         end
         ST_CMP: begin
            if (base_rd_ff == base_ff) begin
               pend_slot_in  = cur_ff;
               pend_fresh_in = 1'b0;
               pend_full_in  = 1'b0;
               state_in      = ST_DONE;
            end else if (next_rd_ff == '0) begin
               state_in = ST_ALLOC;
            end else begin
               cur_in     = next_rd_ff;
               slot_raddr = next_rd_ff;
            end
         end
         ST_ALLOC: begin
            if (victim >= limit) begin
               pend_slot_in  = '0;
               pend_fresh_in = 1'b0;
               pend_full_in  = 1'b1;
            end else begin
               head_we       = 1'b1;
               slot_we       = 1'b1;
               used_in       = victim_slot;
               pend_slot_in  = victim_slot;
               pend_fresh_in = 1'b1;
               pend_full_in  = 1'b0;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (res_free) begin
               res_valid_in  = 1'b1;
               res_slot_in   = pend_slot_ff;
               res_offset_in = offset_ff;
               res_fresh_in  = pend_fresh_ff;
               res_full_in   = pend_full_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         used_ff      <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         used_ff      <= used_in;
         res_valid_ff <= res_valid_in;
      end
   end

   // Item and result payload.
   always_ff @(posedge clock) begin
      base_ff       <= base_in;
      bucket_ff     <= bucket_in;
      offset_ff     <= offset_in;
      head_ff       <= head_in;
      cur_ff        <= cur_in;
      pend_slot_ff  <= pend_slot_in;
      pend_fresh_ff <= pend_fresh_in;
      pend_full_ff  <= pend_full_in;
      res_slot_ff   <= res_slot_in;
      res_offset_ff <= res_offset_in;
      res_fresh_ff  <= res_fresh_in;
      res_full_ff   <= res_full_in;
   end

   // Bucket head memory with registered read.
   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_waddr] <= head_wdata;
      end
      head_rd_ff <= head_mem[item_bucket];
   end

   // Slot memories: a new slot records its base and links to the old head.
   always_ff @(posedge clock) begin
      if (slot_we) begin
         base_mem[victim_slot] <= base_ff;
         next_mem[victim_slot] <= head_ff;
      end
      base_rd_ff <= base_mem[slot_raddr];
      next_rd_ff <= next_mem[slot_raddr];
   end

   // Response word.
   assign slot_ext            = 32'(res_slot_ff);
   assign rsp_empty           = !res_valid_ff;
   assign rsp_pool_slot       = slot_ext[SLOT_OUT_W-1:0];
   assign rsp_page_offset     = res_offset_ff;
   assign rsp_newly_allocated = res_fresh_ff;
   assign rsp_table_full      = res_full_ff;

endmodule

/* rtl/core/segment_pool_translation_table.sv */
`timescale 1ns / 1ps

// Translates a page number into a pool slot and an offset inside that slot by
// walking the hash chain of the page's segment, allocating a new slot at the
// head of the chain on a miss, or flagging table_full when the pool limit is
// reached. Requests enter a two-word queue and are handled one at a time by
// the chain walker, whose memories have a registered read: a lookup reads the
// bucket head, compares the chain entries in order until a hit or the chain's
// end, allocates on a miss and then returns the result. After reset a clearing
// pass writes every bucket head to empty, one per cycle, and req_full stays
// high until it ends; configuration writes are taken during that time.
// Configuration must be written only while no request is in flight.
module segment_pool_translation_table #(
   parameter int BUCKET_BITS = 8,
   parameter int POOL_SLOTS  = 256,
   parameter int PAGE_BITS   = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [sptt_pkg::PAGE_W-1:0]       req_page_number,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [sptt_pkg::SLOT_OUT_W-1:0]   rsp_pool_slot,
   output logic [sptt_pkg::OFFSET_W-1:0]     rsp_page_offset,
   output logic                              rsp_newly_allocated,
   output logic                              rsp_table_full,
   input  logic                              csr_write_enable,
   input  logic [sptt_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sptt_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import sptt_pkg::*;

   localparam int BASE_W = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
   localparam int WORD_W = BASE_W + BUCKET_BITS + OFFSET_W;

   logic [SEG_SHIFT_W-1:0] seg_shift_ff, seg_shift_in;
   logic [LIMIT_W-1:0]     pool_limit_ff, pool_limit_in;

   logic [BASE_W-1:0]      front_base;
   logic [BUCKET_BITS-1:0] front_bucket;
   logic [OFFSET_W-1:0]    front_offset;
   logic [WORD_W-1:0]      queue_out;
   logic                   queue_full;
   logic                   queue_empty;
   walk_status_type        walk_status;

   // Configuration registers.
   always_comb begin
      seg_shift_in  = seg_shift_ff;
      pool_limit_in = pool_limit_ff;
      if (csr_write_enable) begin
         if (csr_index == CSR_SEG_SHIFT) begin
            seg_shift_in = csr_write_data[SEG_SHIFT_W-1:0];
         end else if (csr_index == CSR_POOL_LIMIT) begin
            pool_limit_in = csr_write_data[LIMIT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_shift_ff  <= SEG_SHIFT_RESET;
         pool_limit_ff <= POOL_LIMIT_RESET;
      end else begin
         seg_shift_ff  <= seg_shift_in;
         pool_limit_ff <= pool_limit_in;
      end
   end

   // No request is taken while the bucket heads are being cleared.
   assign req_full = queue_full || walk_status.clearing;

   sptt_front #(
      .BUCKET_BITS (BUCKET_BITS),
      .PAGE_BITS   (PAGE_BITS),
      .BASE_W      (BASE_W)
   ) u_front (
      .page_number (req_page_number),
      .seg_shift   (seg_shift_ff),
      .seg_base    (front_base),
      .bucket      (front_bucket),
      .page_offset (front_offset)
   );

   sptt_fifo #(
      .WIDTH (WORD_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push && !req_full),
      .push_data ({front_base, front_bucket, front_offset}),
      .full      (queue_full),
      .pop       (walk_status.item_pop),
      .pop_data  (queue_out),
      .empty     (queue_empty)
   );

   sptt_walker #(
      .BUCKET_BITS (BUCKET_BITS),
      .POOL_SLOTS  (POOL_SLOTS),
      .BASE_W      (BASE_W)
   ) u_walker (
      .clock               (clock),
      .reset               (reset),
      .item_valid          (!queue_empty),
      .item_base           (queue_out[WORD_W-1:BUCKET_BITS+OFFSET_W]),
      .item_bucket         (queue_out[BUCKET_BITS+OFFSET_W-1:OFFSET_W]),
      .item_offset         (queue_out[OFFSET_W-1:0]),
      .pool_limit          (pool_limit_ff),
      .status              (walk_status),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_pool_slot       (rsp_pool_slot),
      .rsp_page_offset     (rsp_page_offset),
      .rsp_newly_allocated (rsp_newly_allocated),
      .rsp_table_full      (rsp_table_full)
   );

endmodule

/* verif/segment_pool_translation_table_tb.sv */
`timescale 1ns / 1ps

module segment_pool_translation_table_tb;
   import sptt_pkg::*;

   localparam int BUCKET_BITS  = 8;
   localparam int POOL_SLOTS   = 256;
   localparam int BUCKET_COUNT = 1 << BUCKET_BITS;
   localparam int PHASE_WORDS  = 229;
   localparam int SINK_STALL   = 400;
   localparam int SETTLE       = 12;

   // Index outside the register map; a write to it must change nothing.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [SLOT_OUT_W-1:0] slot;
      logic [OFFSET_W-1:0]   offset;
      logic                  fresh;
      logic                  full;
   } xlate_word_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_push = 1'b0;
   logic                   req_full;
   logic [PAGE_W-1:0]      req_page_number = '0;
   logic                   rsp_empty;
   logic                   rsp_pop = 1'b0;
   logic [SLOT_OUT_W-1:0]  rsp_pool_slot;
   logic [OFFSET_W-1:0]    rsp_page_offset;
   logic                   rsp_newly_allocated;
   logic                   rsp_table_full;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   segment_pool_translation_table #(
      .BUCKET_BITS(BUCKET_BITS),
      .POOL_SLOTS (POOL_SLOTS),
      .PAGE_BITS  (PAGE_W)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_page_number    (req_page_number),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_pool_slot      (rsp_pool_slot),
      .rsp_page_offset    (rsp_page_offset),
      .rsp_newly_allocated(rsp_newly_allocated),
      .rsp_table_full     (rsp_table_full),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   // Shadow copy of the translation table and its registers.
   logic [7:0]             head_of_bucket [0:BUCKET_COUNT-1];
   logic [PAGE_W-1:0]      base_of_slot   [0:POOL_SLOTS-1];
   logic [7:0]             next_of_slot   [0:POOL_SLOTS-1];
   int                     slots_taken;
   logic [SEG_SHIFT_W-1:0] model_seg_shift;
   logic [LIMIT_W-1:0]     model_pool_limit;

   logic [PAGE_W-1:0] page_backlog[$];
   logic [PAGE_W-1:0] recent_pages[$];
   xlate_word_type    expected_words[$];

   int  mismatch_count = 0;
   int  words_checked = 0;
   int  stall_requests = 0;
   int  stall_served = 0;
   int  stall_left = 0;
   logic quiet_mode = 1'b0;
   xlate_word_type got_word;
   xlate_word_type want_word;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Look up or allocate the segment of one page, updating the shadow table.
   function automatic xlate_word_type translate_page(input logic [PAGE_W-1:0] page);
      logic [PAGE_W-1:0] low_mask;
      logic [PAGE_W-1:0] seg_base;
      logic [7:0]        bucket;
      int                eff_limit;
      int                slot;
      int                steps;
      int                hit;
      int                victim;
      xlate_word_type    w;
      low_mask  = (32'h1 << model_seg_shift) - 32'h1;
      seg_base  = page & ~low_mask;
      bucket    = 8'(page >> model_seg_shift);
      eff_limit = (model_pool_limit < POOL_SLOTS) ? int'(model_pool_limit) : POOL_SLOTS;
      slot  = head_of_bucket[bucket];
      steps = 0;
      hit   = 0;
      while (slot != 0 && steps < POOL_SLOTS && hit == 0) begin
         if (base_of_slot[slot] == seg_base) begin
            hit = slot;
         end else begin
            slot = next_of_slot[slot];
            steps++;
         end
      end
      w.fresh = 1'b0;
      w.full  = 1'b0;
      // A miss takes the next slot, linked at the head of its bucket.
      if (hit == 0) begin
         victim = slots_taken + 1;
         if (victim >= eff_limit) begin
            w.full = 1'b1;
         end else begin
            slots_taken            = victim;
            base_of_slot[victim]   = seg_base;
            next_of_slot[victim]   = head_of_bucket[bucket];
            head_of_bucket[bucket] = 8'(victim);
            hit                    = victim;
            w.fresh                = 1'b1;
         end
      end
      w.slot   = 8'(hit);
      w.offset = 16'(page & low_mask);
      return w;
   endfunction

   // Mostly pages from a few crowded buckets or recently seen ones, some noise.
   function automatic logic [PAGE_W-1:0] pick_page(input int sb);
      logic [63:0] wide;
      int          roll;
      roll = $urandom_range(0, 99);
      if (roll < 10)
         return $urandom;
      if (roll < 60 && recent_pages.size() > 0)
         return recent_pages[$urandom_range(0, recent_pages.size() - 1)];
      wide = (64'($urandom_range(0, 7)) << (sb + 8))
           | (64'($urandom_range(0, 7)) << sb)
           | (64'($urandom) & ((64'h1 << sb) - 64'h1));
      return wide[PAGE_W-1:0];
   endfunction

   task automatic queue_page(input logic [PAGE_W-1:0] page);
      page_backlog.push_back(page);
   endtask

   // Hold off new words until every expected result has come back.
   task automatic drain;
      while (expected_words.size() != 0 || page_backlog.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (index == CSR_SEG_SHIFT)
         model_seg_shift = data[SEG_SHIFT_W-1:0];
      else if (index == CSR_POOL_LIMIT)
         model_pool_limit = data[LIMIT_W-1:0];
   endtask

   // Request driver: offers the oldest pending word unless it idles this cycle.
   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else if (page_backlog.size() != 0 &&
                   (quiet_mode || $urandom_range(0, 99) >= 15)) begin
         req_push        <= 1'b1;
         req_page_number <= page_backlog[0];
      end else begin
         req_push <= 1'b0;
      end
   end

   // Result sink: random idling, plus long hold-offs on request.
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (stall_served != stall_requests) begin
         stall_served++;
         stall_left = SINK_STALL;
         rsp_pop <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= quiet_mode || ($urandom_range(0, 99) >= 15);
      end
   end

   // Monitor: check each popped result word, then predict each accepted word.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            got_word = {rsp_pool_slot, rsp_page_offset, rsp_newly_allocated, rsp_table_full};
            if (expected_words.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result word: slot=%0d offset=%h new=%b full=%b",
                           got_word.slot, got_word.offset, got_word.fresh, got_word.full);
            end else begin
               want_word = expected_words.pop_front();
               if (got_word.slot !== want_word.slot || got_word.offset !== want_word.offset ||
                   got_word.fresh !== want_word.fresh || got_word.full !== want_word.full) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("word %0d: expected slot=%0d offset=%h new=%b full=%b, %s",
                              words_checked, want_word.slot, want_word.offset,
                              want_word.fresh, want_word.full,
                              $sformatf("got slot=%0d offset=%h new=%b full=%b",
                                        got_word.slot, got_word.offset,
                                        got_word.fresh, got_word.full));
               end
            end
            words_checked++;
         end
         if (req_push && !req_full) begin
            expected_words.push_back(translate_page(req_page_number));
            void'(page_backlog.pop_front());
         end
      end
   end

   initial begin
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      int               p;
      int               n;
      int               sb;
      int               cap;
      logic [LIMIT_W-1:0] lim;
      logic [PAGE_W-1:0]  page;

      for (int i = 0; i < BUCKET_COUNT; i++)
         head_of_bucket[i] = '0;
      for (int i = 0; i < POOL_SLOTS; i++) begin
         base_of_slot[i] = '0;
         next_of_slot[i] = '0;
      end
      slots_taken      = 0;
      model_seg_shift  = SEG_SHIFT_RESET;
      model_pool_limit = POOL_LIMIT_RESET;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: hits, misses, extremes and a chain in one bucket.
      queue_page(32'h0000_0000);
      queue_page(32'h0000_0000);
      queue_page(32'h0000_000F);
      queue_page(32'hFFFF_FFFF);
      queue_page(32'hFFFF_FFF0);
      queue_page(32'h0000_1000);
      queue_page(32'h0000_2005);
      queue_page(32'h0000_1003);
      queue_page(32'h0000_0001);
      queue_page(32'h8000_0000);
      queue_page(32'h7FFF_FFFF);
      queue_page(32'h5555_5555);
      queue_page(32'hAAAA_AAAA);
      drain();

      // No offset bits at all.
      write_register(CSR_SEG_SHIFT, 9'h000);
      queue_page(32'h0000_0100);
      queue_page(32'h0000_0000);
      drain();

      // Widest regular segment, then the wide case where the offset is cut to 16 bits.
      write_register(CSR_SEG_SHIFT, 9'h010);
      queue_page(32'h1234_ABCD);
      queue_page(32'h1234_FFFF);
      drain();
      write_register(CSR_SEG_SHIFT, 9'h1FF);
      queue_page(32'hFFFF_FFFF);
      queue_page(32'h7FFF_FFFF);
      drain();

      // Table full: the next slot reaches the limit, and limits from zero to two.
      write_register(CSR_SEG_SHIFT, 9'h004);
      write_register(CSR_POOL_LIMIT, LIMIT_W'(slots_taken + 1));
      queue_page(32'h0BAD_0000);
      queue_page(32'h0000_0000);
      drain();
      write_register(CSR_POOL_LIMIT, 9'd0);
      queue_page(32'h0BAD_1000);
      drain();
      write_register(CSR_POOL_LIMIT, 9'd1);
      queue_page(32'hC0DE_0000);
      drain();
      write_register(CSR_POOL_LIMIT, 9'd2);
      queue_page(32'h0BAD_2000);
      drain();
      write_register(CSR_UNUSED, 9'h0AA);

      // Random phases, each with its own segment size and pool limit.
      for (p = 0; p < 8; p++) begin
         case (p)
            0: sb = 4;
            1: sb = 0;
            2: sb = 16;
            3: sb = 31;
            default: sb = $urandom_range(0, 31);
         endcase
         write_register(CSR_SEG_SHIFT, {4'($urandom_range(0, 15)), 5'(sb)});
         case (p)
            3: lim = 9'h1FF;
            5: lim = 9'd1;
            6: lim = 9'd256;
            default: begin
               cap = slots_taken + 1 + $urandom_range(10, 35);
               lim = (cap > POOL_SLOTS) ? LIMIT_W'(POOL_SLOTS) : LIMIT_W'(cap);
            end
         endcase
         write_register(CSR_POOL_LIMIT, lim);
         quiet_mode = (p == 2);
         for (n = 0; n < PHASE_WORDS; n++) begin
            page = pick_page(sb);
            queue_page(page);
            recent_pages.push_back(page);
            if (recent_pages.size() > 48)
               void'(recent_pages.pop_front());
         end
         // Back up the block while the backlog is full of words.
         if (p == 1 || p == 4)
            stall_requests++;
         drain();
      end
      quiet_mode = 1'b0;

      drain();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
